@@ hw/rtl/lgs_pkg.sv @@
// Shared constants and controller/datapath interface types for the Life generation step.
`default_nettype none
package lgs_pkg;

  // Grid size in cells.
  localparam int WIDTH  = 32;
  localparam int HEIGHT = 32;

  // Row index width and the widths of the stream payloads.
  localparam int ROW_IDX_W   = $clog2(HEIGHT);
  localparam int CELLS_W     = 32;
  localparam int ROW_NUM_W   = 5;
  localparam int OUT_FIELD_W = CELLS_W + ROW_NUM_W;
  localparam int OUT_DATA_W  = ((OUT_FIELD_W + 7) / 8) * 8;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;   // store the incoming row
    logic emit;   // compute one new row into the output register
  } lgs_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic load_last;  // the next stored row completes the grid
    logic emit_last;  // the row being computed is the bottom row
    logic out_free;   // the output register can take a new row
  } lgs_status_t;

endpackage
`default_nettype wire

@@ hw/rtl/lgs_ctrl.sv @@
// Controller state machine: alternates between loading the grid and emitting a generation.
`default_nettype none
module lgs_ctrl
  import lgs_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire lgs_status_t status,
  output lgs_cmd_t         cmd
);

  typedef enum logic [1:0] {
    ST_LOAD = 2'b01,
    ST_EMIT = 2'b10
  } state_t;

  state_t state;
  state_t state_next;

  // Command decode and next-state selection.
  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    cmd        = '0;
    case (state)
      ST_LOAD: begin
        s_tready = 1'b1;
        cmd.load = s_tvalid;
        if (s_tvalid && status.load_last) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        cmd.emit = status.out_free;
        if (status.out_free && status.emit_last) begin
          state_next = ST_LOAD;
        end
      end
      default: begin
        state_next = ST_LOAD;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/lgs_datapath.sv @@
// Datapath: grid row memory, three-row window, Life rule and output register.
`default_nettype none
module lgs_datapath
  import lgs_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire lgs_cmd_t              cmd,
  output lgs_status_t                status,
  input  wire logic [CELLS_W-1:0]    in_row,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [CELLS_W-1:0]         out_cells,
  output logic [ROW_NUM_W-1:0]       out_row_num,
  output logic                       out_final
);

  localparam logic [ROW_IDX_W-1:0] LAST_ROW = ROW_IDX_W'(HEIGHT - 1);

  // Grid row memory, one write port and one registered read port.
  logic [WIDTH-1:0]     mem [HEIGHT];
  logic [WIDTH-1:0]     rd_data;
  logic [ROW_IDX_W-1:0] rd_addr;
  logic                 rd_en;

  logic [ROW_IDX_W-1:0] load_cnt;
  logic [ROW_IDX_W-1:0] emit_cnt;
  logic [ROW_IDX_W:0]   emit_ahead;

  // Row window: the row above, the current row, and the saved top row for wrap.
  logic [WIDTH-1:0] prev_row;
  logic [WIDTH-1:0] cur_row;
  logic [WIDTH-1:0] top_row;
  logic [WIDTH-1:0] next_row;
  logic [WIDTH-1:0] in_masked;
  logic [WIDTH-1:0] life_row;

  // One generation of the rule for a row, with columns wrapping around.
  function automatic logic [WIDTH-1:0] life_step(input logic [WIDTH-1:0] above,
                                                 input logic [WIDTH-1:0] mid,
                                                 input logic [WIDTH-1:0] below);
    logic [WIDTH-1:0] res;
    logic [3:0]       cnt;
    int               xl;
    int               xr;
    res = '0;
    for (int x = 0; x < WIDTH; x++) begin
      xl  = (x == 0) ? WIDTH - 1 : x - 1;
      xr  = (x == WIDTH - 1) ? 0 : x + 1;
      cnt = 4'(above[xl]) + 4'(above[x]) + 4'(above[xr]) + 4'(mid[xl]) + 4'(mid[xr])
          + 4'(below[xl]) + 4'(below[x]) + 4'(below[xr]);
      res[x] = (cnt == 4'd3) || (mid[x] && (cnt == 4'd2));
    end
    return res;
  endfunction

  assign in_masked  = WIDTH'(in_row);
  assign next_row   = (emit_cnt == LAST_ROW) ? top_row : rd_data;
  assign life_row   = life_step(prev_row, cur_row, next_row);
  assign emit_ahead = {1'b0, emit_cnt} + (ROW_IDX_W + 1)'(2);

  // The first read of a generation fetches row one; later reads run two rows ahead.
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = ROW_IDX_W'(1);
    if (cmd.load && status.load_last) begin
      rd_en = 1'b1;
    end else if (cmd.emit && (emit_ahead < (ROW_IDX_W + 1)'(HEIGHT))) begin
      rd_en   = 1'b1;
      rd_addr = emit_ahead[ROW_IDX_W-1:0];
    end
  end

  assign status.load_last = (load_cnt == LAST_ROW);
  assign status.emit_last = (emit_cnt == LAST_ROW);
  assign status.out_free  = !out_valid || out_ready;

  // Memory write and read.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mem[load_cnt] <= in_masked;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Row counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      load_cnt <= '0;
      emit_cnt <= '0;
    end else begin
      if (cmd.load) begin
        load_cnt <= status.load_last ? '0 : load_cnt + ROW_IDX_W'(1);
      end
      if (cmd.emit) begin
        emit_cnt <= status.emit_last ? '0 : emit_cnt + ROW_IDX_W'(1);
      end
    end
  end

  // Row window: primed by the last loaded row, slid down by each emitted row.
  always_ff @(posedge clk) begin
    if (cmd.load && (load_cnt == '0)) begin
      top_row <= in_masked;
    end
    if (cmd.load && status.load_last) begin
      prev_row <= in_masked;
      cur_row  <= top_row;
    end else if (cmd.emit) begin
      prev_row <= cur_row;
      cur_row  <= next_row;
    end
  end

  // Output register, decoupled from the input side.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_cells   <= CELLS_W'(life_row);
      out_row_num <= ROW_NUM_W'(emit_cnt);
      out_final   <= status.emit_last;
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/life_generation_step_core.sv @@
// Top level of the Life generation step: stream ports, controller and datapath.
//
// Rows of the grid arrive one per transaction, top row first, and are stored at one per
// cycle. The transaction that delivers the bottom row starts a generation: the block then
// stops accepting rows and emits all HEIGHT new rows in order, one per cycle while the
// output is taken. After the bottom row is accepted the controller enters its emit state
// and writes the first new row into the output register once that register is free. The
// single read port of the row memory, read one row ahead, sets the emit pace. Loading of
// the next grid may begin while the last new row still waits in the output register. Row
// and column edges wrap around.
`default_nettype none
module life_generation_step_core
  import lgs_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [CELLS_W-1:0]    s_tdata,   // [31:0] row_cells
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic [OUT_DATA_W-1:0]      m_tdata,   // [31:0] next_row_cells, [36:32] row_number
  output logic                       m_tlast    // final_row
);

  lgs_cmd_t                cmd;
  lgs_status_t             status;
  logic [CELLS_W-1:0]      out_cells;
  logic [ROW_NUM_W-1:0]    out_row_num;

  lgs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  lgs_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .in_row      (s_tdata),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_cells   (out_cells),
    .out_row_num (out_row_num),
    .out_final   (m_tlast)
  );

  // Pack the result fields, lowest field first, zero filled to whole bytes.
  assign m_tdata = OUT_DATA_W'({out_row_num, out_cells});

endmodule
`default_nettype wire

@@ test/life_step_checker.sv @@
// Stream monitor that predicts each Life generation and compares the emitted rows.
module life_step_checker
  import lgs_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_tvalid,
  input  wire logic                  s_tready,
  input  wire logic [CELLS_W-1:0]    s_tdata,   // [31:0] row_cells
  input  wire logic                  m_tvalid,
  input  wire logic                  m_tready,
  input  wire logic [OUT_DATA_W-1:0] m_tdata,   // [31:0] next_row_cells, [36:32] row_number
  input  wire logic                  m_tlast,   // final_row
  output int                         mismatch_count,
  output int                         rows_outstanding,
  output int                         rows_checked
);

  // Neighbor counts that keep a live cell alive or bring a dead one to life.
  localparam int SURVIVE_COUNT = 2;
  localparam int BIRTH_COUNT   = 3;

  typedef bit [WIDTH-1:0] cells_t;

  typedef struct {
    cells_t               cells;
    bit [ROW_NUM_W-1:0]   row_num;
    bit                   last;
  } new_row_t;

  cells_t   loaded_grid [HEIGHT];
  cells_t   evolved_grid [HEIGHT];
  int       rows_loaded_cnt;
  new_row_t expected_rows [$];

  // New state of one row from the three stored rows around it, wrapping on both axes.
  function automatic cells_t evolve_row(int y);
    cells_t above;
    cells_t mid;
    cells_t below;
    cells_t res;
    bit [7:0] nb;
    int xl;
    int xr;
    int cnt;
    above = loaded_grid[(y + HEIGHT - 1) % HEIGHT];
    mid   = loaded_grid[y];
    below = loaded_grid[(y + 1) % HEIGHT];
    res   = '0;
    for (int x = 0; x < WIDTH; x++) begin
      xl  = (x + WIDTH - 1) % WIDTH;
      xr  = (x + 1) % WIDTH;
      nb  = {above[xl], above[x], above[xr], mid[xl], mid[xr],
             below[xl], below[x], below[xr]};
      cnt = $countones(nb);
      if (mid[x])
        res[x] = (cnt == SURVIVE_COUNT) || (cnt == BIRTH_COUNT);
      else
        res[x] = (cnt == BIRTH_COUNT);
    end
    return res;
  endfunction

  // Compute the whole next generation, queue its rows and keep it as the new grid.
  function automatic void queue_generation();
    new_row_t item;
    for (int y = 0; y < HEIGHT; y++)
      evolved_grid[y] = evolve_row(y);
    for (int y = 0; y < HEIGHT; y++) begin
      loaded_grid[y] = evolved_grid[y];
      item.cells     = evolved_grid[y];
      item.row_num   = ROW_NUM_W'(y);
      item.last      = (y == HEIGHT - 1);
      expected_rows.push_back(item);
    end
  endfunction

  initial begin
    mismatch_count   = 0;
    rows_outstanding = 0;
    rows_checked     = 0;
    rows_loaded_cnt  = 0;
  end

  // Sample both channels at the rising edge, before the block's registers move.
  always @(posedge clk) begin
    new_row_t exp_row;
    if (rst) begin
      rows_loaded_cnt = 0;
      expected_rows.delete();
    end else begin
      // Output transaction: compare against the oldest queued row.
      if (m_tvalid && m_tready) begin
        if (expected_rows.size() == 0) begin
          $error("unexpected output transaction, tdata %0h tlast %0b", m_tdata, m_tlast);
          mismatch_count++;
        end else begin
          exp_row = expected_rows.pop_front();
          rows_checked++;
          if (m_tdata[CELLS_W-1:0] !== exp_row.cells) begin
            $error("next_row_cells: expected %0h, actual %0h",
                   exp_row.cells, m_tdata[CELLS_W-1:0]);
            mismatch_count++;
          end
          if (m_tdata[CELLS_W +: ROW_NUM_W] !== exp_row.row_num) begin
            $error("row_number: expected %0d, actual %0d",
                   exp_row.row_num, m_tdata[CELLS_W +: ROW_NUM_W]);
            mismatch_count++;
          end
          if (m_tdata[OUT_DATA_W-1:OUT_FIELD_W] !== '0) begin
            $error("tdata padding: expected 0, actual %0h",
                   m_tdata[OUT_DATA_W-1:OUT_FIELD_W]);
            mismatch_count++;
          end
          if (m_tlast !== exp_row.last) begin
            $error("final_row: expected %0b, actual %0b", exp_row.last, m_tlast);
            mismatch_count++;
          end
        end
      end
      // Input transaction: store the row; the bottom row triggers a generation.
      if (s_tvalid && s_tready) begin
        loaded_grid[rows_loaded_cnt] = s_tdata;
        rows_loaded_cnt++;
        if (rows_loaded_cnt == HEIGHT) begin
          queue_generation();
          rows_loaded_cnt = 0;
        end
      end
    end
    rows_outstanding = expected_rows.size();
  end

endmodule

@@ test/testbench.sv @@
// Top of the Life generation step testbench: clock, reset, row stimulus and verdict.
module testbench
  import lgs_pkg::*;
;

  localparam int RANDOM_GENS  = 10;
  localparam int DRAIN_CYCLES = 3 * HEIGHT;
  localparam int CYCLE_LIMIT  = 300000;

  logic                  clk;
  logic                  rst      = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [CELLS_W-1:0]    s_tdata  = '0;   // [31:0] row_cells
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;         // [31:0] next_row_cells, [36:32] row_number
  logic                  m_tlast;         // final_row

  int mismatch_count;
  int rows_outstanding;
  int rows_checked;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int rows_sent   = 0;
  int cycle_count = 0;

  life_generation_step_core u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  life_step_checker u_checker (
    .clk              (clk),
    .rst              (rst),
    .s_tvalid         (s_tvalid),
    .s_tready         (s_tready),
    .s_tdata          (s_tdata),
    .m_tvalid         (m_tvalid),
    .m_tready         (m_tready),
    .m_tdata          (m_tdata),
    .m_tlast          (m_tlast),
    .mismatch_count   (mismatch_count),
    .rows_outstanding (rows_outstanding),
    .rows_checked     (rows_checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver backpressure, redrawn every cycle.
  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Hand one row to the block, with random idle cycles ahead of it.
  task automatic send_row(input logic [CELLS_W-1:0] cells);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= cells;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    rows_sent++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    while (rows_outstanding != 0) @(negedge clk);
  endtask

  // Opening grid: a glider straddling the corner, a block across the side edges,
  // a blinker, full, empty and checkered rows.
  function automatic logic [CELLS_W-1:0] directed_row(int y);
    case (y)
      0:       return 32'h0000_0002;
      1:       return 32'h8000_0003;
      4:       return 32'hFFFF_FFFF;
      6:       return 32'hAAAA_AAAA;
      7:       return 32'h5555_5555;
      11:      return 32'h0001_C000;
      15, 16:  return 32'h8000_0001;
      20:      return 32'hFFFF_0000;
      21:      return 32'h0000_FFFF;
      25:      return 32'h8000_0000;
      26:      return 32'hC000_0000;
      27:      return 32'h0000_0001;
      HEIGHT - 1: return 32'h0000_0001;
      default: return 32'h0000_0000;
    endcase
  endfunction

  // Random row with a density drawn per row, so some generations die out and some crowd.
  function automatic logic [CELLS_W-1:0] random_row();
    case ($urandom_range(5))
      0:       return $urandom() & $urandom();
      1:       return $urandom() & $urandom() & $urandom();
      2:       return $urandom() | $urandom();
      3:       return ($urandom_range(1) != 0) ? 32'hFFFF_FFFF : 32'h0000_0000;
      default: return $urandom();
    endcase
  endfunction

  initial begin
    // Reset held once, at the start of the run.
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Sender idles lightly, receiver heavily.
    tx_idle_pct = 35;
    rx_idle_pct = 87;
    for (int y = 0; y < HEIGHT; y++)
      send_row(directed_row(y));

    for (int g = 0; g < RANDOM_GENS; g++) begin
      if (g == 3) begin
        // Hold the sender until the current generation has fully drained.
        s_tvalid <= 1'b0;
        wait_drained();
        tx_idle_pct = 87;
        rx_idle_pct = 35;
      end else if (g == 7) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      for (int y = 0; y < HEIGHT; y++)
        send_row(random_row());
    end
    s_tvalid <= 1'b0;

    // Let the last generation drain, then watch for stray output.
    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Loaded %0d grid rows (%0d generations) and compared %0d evolved rows,",
             rows_sent, rows_sent / HEIGHT, rows_checked);
    $display("under heavy receiver stall, heavy sender gaps and full-rate streaming.");
    if (mismatch_count == 0 && rows_outstanding == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
